/* hw/rtl/amfr_pkg.sv */
// Shared types and constants of the marker frame receiver.
`timescale 1ns / 1ps

package amfr_pkg;

    // Frame store depth and the widest frame length it can hold.
    localparam int C_BUF_DEPTH     = 64;
    localparam int C_BUF_DEPTH_MAX = 64;
    localparam int C_LEN_W         = $clog2(C_BUF_DEPTH_MAX + 1);

    localparam int C_MIN_FRAME     = 10;
    localparam int C_PAY_FIRST     = 6;
    localparam int C_PAY_TAIL      = 5;
    localparam int C_JOBQ_DEPTH    = 2;

    localparam logic [15:0] C_TIMEOUT_RESET = 16'd15000;

    localparam logic C_OP_BYTE = 1'b0;
    localparam logic C_OP_TICK = 1'b1;

    localparam logic [1:0] C_KIND_ACK  = 2'd0;
    localparam logic [1:0] C_KIND_NAK  = 2'd1;
    localparam logic [1:0] C_KIND_DATA = 2'd2;

    localparam logic [7:0] C_CH_A = 8'h41;
    localparam logic [7:0] C_CH_B = 8'h42;
    localparam logic [7:0] C_CH_C = 8'h43;
    localparam logic [7:0] C_CH_E = 8'h45;
    localparam logic [7:0] C_CH_H = 8'h48;
    localparam logic [7:0] C_CH_K = 8'h4B;
    localparam logic [7:0] C_CH_M = 8'h4D;
    localparam logic [7:0] C_CH_O = 8'h4F;
    localparam logic [7:0] C_CH_S = 8'h53;
    localparam logic [7:0] C_CH_T = 8'h54;
    localparam logic [7:0] C_CH_X = 8'h58;

    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] reply_kind;
        logic [7:0] payload_byte;
        logic       start_was_soh;
        logic       end_was_etb;
        logic       last;
    } t_out_item;

    // Work handed from the front to the back for one finished frame or timeout.
    typedef struct packed {
        logic               nak;
        logic [C_LEN_W-1:0] len;
        logic               soh;
        logic               etb;
    } t_job;

    typedef struct packed {
        logic               en;
        logic [C_LEN_W-1:0] addr;
        logic [7:0]         data;
    } t_mem_wr;

    typedef struct packed {
        logic done;
    } t_back_sts;

endpackage

/* hw/rtl/amfr_jobq.sv */
// Short job queue between the frame parser and the reply sequencer.
`timescale 1ns / 1ps

module amfr_jobq
    import amfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PW = (C_JOBQ_DEPTH > 1) ? $clog2(C_JOBQ_DEPTH) : 1;
    localparam int NW = $clog2(C_JOBQ_DEPTH + 1);

    t_job          r_mem [C_JOBQ_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == NW'(C_JOBQ_DEPTH));

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(C_JOBQ_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(C_JOBQ_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("job pushed into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job popped from an empty queue");

endmodule

/* hw/rtl/amfr_front.sv */
// Front part: marker matching, frame storage, LRC check and timeout.
`timescale 1ns / 1ps

module amfr_front
    import amfr_pkg::*;
#(
    parameter int BUF_DEPTH = C_BUF_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  logic [15:0] i_timeout,
    input  logic      i_q_full,
    input  t_back_sts i_sts,
    output logic      o_full,
    output logic      o_job_push,
    output t_job      o_job,
    output t_mem_wr   o_wr
);

    localparam int CW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_S    = 10'b00_0000_0010,
        S_SEC  = 10'b00_0000_0100,
        S_BODY = 10'b00_0000_1000,
        S_E    = 10'b00_0001_0000,
        S_ET   = 10'b00_0010_0000,
        S_ETX  = 10'b00_0100_0000,
        S_ETB  = 10'b00_1000_0000,
        S_A    = 10'b01_0000_0000,
        S_AC   = 10'b10_0000_0000
    } t_mstate;

    t_mstate       r_state, n_state;
    logic          r_soh, n_soh;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_id0, n_id0;
    logic [7:0]    r_id1, n_id1;
    logic [7:0]    r_id2, n_id2;
    logic          r_tmr_act, n_tmr_act;
    logic [15:0]   r_tmr_rem, n_tmr_rem;
    logic          r_disp_pend, n_disp_pend;

    logic [7:0]    c;
    t_mstate       m_next;
    logic          m_soh;
    logic          m_clr;
    logic          m_arm;
    logic          m_lrc;
    logic          store;
    logic [CW-1:0] base_cnt;
    logic [CW-1:0] inc_cnt;
    logic [7:0]    base_xor;
    logic          overflow;
    logic          id_reject;
    logic          is_nak;

    assign c      = i_item.byte_value;
    assign o_full = i_q_full || r_disp_pend;

    // Marker matcher: one step per received byte.
    always_comb begin
        m_next = r_state;
        m_soh  = r_soh;
        m_clr  = 1'b0;
        m_arm  = 1'b0;
        m_lrc  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (c == C_CH_S) begin
                    m_next = S_S;
                end else if (c == C_CH_A) begin
                    m_next = S_A;
                end
            end
            S_S: begin
                if (c == C_CH_T) begin
                    m_next = S_SEC;
                    m_soh  = 1'b0;
                end else if (c == C_CH_O) begin
                    m_next = S_SEC;
                    m_soh  = 1'b1;
                end else if (c == C_CH_S) begin
                    m_clr = 1'b1;
                end else begin
                    m_next = S_IDLE;
                end
            end
            S_SEC: begin
                if (c == (r_soh ? C_CH_H : C_CH_X)) begin
                    m_next = S_BODY;
                    m_arm  = 1'b1;
                end else if (c == C_CH_S) begin
                    m_next = S_S;
                    m_clr  = 1'b1;
                end else begin
                    m_next = S_IDLE;
                end
            end
            S_BODY: begin
                if (c == C_CH_E) begin
                    m_next = S_E;
                end
            end
            S_E: begin
                if (c == C_CH_T) begin
                    m_next = S_ET;
                end else if (c != C_CH_E) begin
                    m_next = S_BODY;
                end
            end
            S_ET: begin
                if (c == C_CH_X) begin
                    m_next = S_ETX;
                end else if (c == C_CH_B) begin
                    m_next = S_ETB;
                end else if (c == C_CH_E) begin
                    m_next = S_E;
                end else begin
                    m_next = S_BODY;
                end
            end
            S_ETX, S_ETB: begin
                m_lrc  = 1'b1;
                m_next = S_IDLE;
            end
            S_A: begin
                if (c == C_CH_C) begin
                    m_next = S_AC;
                end else if (c != C_CH_A) begin
                    m_next = S_IDLE;
                end
            end
            S_AC: begin
                // A completed idle sequence also lands here in idle, storing nothing.
                if (c == C_CH_A) begin
                    m_next = S_A;
                end else begin
                    m_next = S_IDLE;
                end
            end
            default: begin
                m_next = S_IDLE;
            end
        endcase
    end

    assign store    = m_lrc || !(m_next == S_IDLE || m_next == S_A || m_next == S_AC);
    assign base_cnt = m_clr ? '0 : r_cnt;
    assign base_xor = m_clr ? 8'h00 : r_xor;
    assign inc_cnt  = base_cnt + CW'(1);
    assign overflow = (inc_cnt == CW'(BUF_DEPTH));

    assign id_reject = (r_id0 == C_CH_M && r_id1 == C_CH_C && r_id2 == C_CH_T) ||
                       (r_id0 == C_CH_X && r_id1 == C_CH_X && r_id2 == C_CH_X);
    assign is_nak    = (inc_cnt < CW'(C_MIN_FRAME)) || (base_xor != c) || id_reject;

    always_comb begin
        n_state     = r_state;
        n_soh       = r_soh;
        n_cnt       = r_cnt;
        n_xor       = r_xor;
        n_id0       = r_id0;
        n_id1       = r_id1;
        n_id2       = r_id2;
        n_tmr_act   = r_tmr_act;
        n_tmr_rem   = r_tmr_rem;
        n_disp_pend = r_disp_pend && !i_sts.done;
        o_job_push  = 1'b0;
        o_job       = '0;
        o_wr        = '0;
        if (i_accept) begin
            if (i_item.opcode == C_OP_TICK) begin
                if (r_tmr_act) begin
                    if (r_tmr_rem <= 16'd1) begin
                        n_tmr_act  = 1'b0;
                        n_tmr_rem  = 16'd0;
                        n_state    = S_IDLE;
                        n_cnt      = '0;
                        n_xor      = 8'h00;
                        o_job_push = 1'b1;
                        o_job.nak  = 1'b1;
                    end else begin
                        n_tmr_rem = r_tmr_rem - 16'd1;
                    end
                end
            end else begin
                n_state = m_next;
                n_soh   = m_soh;
                if (m_arm) begin
                    n_tmr_act = 1'b1;
                    n_tmr_rem = i_timeout;
                end
                if (m_lrc) begin
                    n_tmr_act = 1'b0;
                end
                if (!store) begin
                    n_cnt = '0;
                    n_xor = 8'h00;
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = C_LEN_W'(base_cnt);
                    o_wr.data = c;
                    if (base_cnt == CW'(3)) begin
                        n_id0 = c;
                    end
                    if (base_cnt == CW'(4)) begin
                        n_id1 = c;
                    end
                    if (base_cnt == CW'(5)) begin
                        n_id2 = c;
                    end
                    if (overflow) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                        n_xor   = 8'h00;
                    end else if (m_lrc) begin
                        n_cnt      = '0;
                        n_xor      = 8'h00;
                        o_job_push = 1'b1;
                        o_job.nak  = is_nak;
                        o_job.len  = C_LEN_W'(inc_cnt);
                        o_job.soh  = r_soh;
                        o_job.etb  = (r_state == S_ETB);
                        if (!is_nak) begin
                            n_disp_pend = 1'b1;
                        end
                    end else begin
                        n_cnt = inc_cnt;
                        n_xor = base_xor ^ c;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id0 <= n_id0;
        r_id1 <= n_id1;
        r_id2 <= n_id2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_soh       <= 1'b0;
            r_cnt       <= '0;
            r_xor       <= 8'h00;
            r_tmr_act   <= 1'b0;
            r_tmr_rem   <= 16'd0;
            r_disp_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_soh       <= n_soh;
            r_cnt       <= n_cnt;
            r_xor       <= n_xor;
            r_tmr_act   <= n_tmr_act;
            r_tmr_rem   <= n_tmr_rem;
            r_disp_pend <= n_disp_pend;
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_A || r_state == S_AC) |-> (r_cnt == '0))
        else $error("frame bytes held outside a frame");

    a_one_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disp_pend |-> !o_job_push)
        else $error("new job raised while a payload dispatch is outstanding");

endmodule

/* hw/rtl/amfr_back.sv */
// Back part: frame store and reply sequencer feeding the result register.
`timescale 1ns / 1ps

module amfr_back
    import amfr_pkg::*;
#(
    parameter int BUF_DEPTH = C_BUF_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mem_wr   i_wr,
    input  logic      i_q_empty,
    input  t_job      i_job,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out,
    output t_back_sts o_sts
);

    localparam int AW = $clog2(BUF_DEPTH);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_WAIT = 3'b010,
        B_EMIT = 3'b100
    } t_bstate;

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd;

    t_bstate       r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_last_idx, n_last_idx;
    logic          r_soh, n_soh;
    logic          r_etb, n_etb;
    logic          r_out_vld, n_out_vld;
    t_out_item     r_out, n_out;

    logic          slot_free;
    logic          out_load;
    logic          ack_last;

    assign o_empty   = !r_out_vld;
    assign o_out     = r_out;
    assign slot_free = !r_out_vld || i_pop;
    assign ack_last  = (i_job.len == C_LEN_W'(C_MIN_FRAME));

    // Frame store: written by the front, read one payload byte at a time.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd <= r_mem[r_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_last_idx = r_last_idx;
        n_soh      = r_soh;
        n_etb      = r_etb;
        n_out      = r_out;
        out_load   = 1'b0;
        o_q_pop    = 1'b0;
        o_sts.done = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && slot_free) begin
                    o_q_pop  = 1'b1;
                    out_load = 1'b1;
                    n_out    = '0;
                    if (i_job.nak) begin
                        n_out.reply_kind = C_KIND_NAK;
                        n_out.last       = 1'b1;
                    end else begin
                        n_out.reply_kind = C_KIND_ACK;
                        n_out.last       = ack_last;
                        if (ack_last) begin
                            o_sts.done = 1'b1;
                        end else begin
                            n_addr     = AW'(C_PAY_FIRST);
                            n_last_idx = AW'(i_job.len - C_LEN_W'(C_PAY_TAIL));
                            n_soh      = i_job.soh;
                            n_etb      = i_job.etb;
                            n_state    = B_WAIT;
                        end
                    end
                end
            end
            B_WAIT: begin
                // The store read of the new address lands in r_rd this cycle.
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (slot_free) begin
                    out_load            = 1'b1;
                    n_out.reply_kind    = C_KIND_DATA;
                    n_out.payload_byte  = r_rd;
                    n_out.start_was_soh = r_soh;
                    n_out.end_was_etb   = r_etb;
                    n_out.last          = (r_addr == r_last_idx);
                    if (r_addr == r_last_idx) begin
                        o_sts.done = 1'b1;
                        n_state    = B_IDLE;
                    end else begin
                        n_addr  = r_addr + AW'(1);
                        n_state = B_WAIT;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        n_out_vld = out_load || (r_out_vld && !i_pop);
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_last_idx <= n_last_idx;
        r_soh      <= n_soh;
        r_etb      <= n_etb;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_addr_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT || r_state == B_WAIT) |-> (r_addr <= r_last_idx))
        else $error("payload read ran past the last payload byte");

endmodule

/* hw/rtl/ascii_marker_frame_receiver_core.sv */
// Top level of the marker frame receiver: configuration register and part wiring.
`timescale 1ns / 1ps

// Each received byte or timer tick is taken by the parser, which matches the
// start and end markers, writes the frame store and checks the LRC. Timeouts
// and rejected frames leave as a single NAK through a two-entry job queue, so
// input keeps flowing while a reply waits in the result register. An accepted
// frame produces an ACK and then its payload bytes, if any, read from the frame
// store through a wait state and an emit state per byte; input is held off
// (full high) from the LRC byte until the last payload byte has entered the
// result register, and any output stall lengthens the hold-off. The timeout
// register may be written at any time the block is idle.

module ascii_marker_frame_receiver_core
    import amfr_pkg::*;
#(
    parameter int BUF_DEPTH = C_BUF_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_timeout;
    logic        accept;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    t_job        job_in;
    t_job        job_out;
    t_mem_wr     mem_wr;
    t_back_sts   back_sts;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= C_TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    amfr_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in),
        .i_timeout  (r_timeout),
        .i_q_full   (q_full),
        .i_sts      (back_sts),
        .o_full     (full),
        .o_job_push (q_push),
        .o_job      (job_in),
        .o_wr       (mem_wr)
    );

    amfr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    amfr_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mem_wr),
        .i_q_empty (q_empty),
        .i_job     (job_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out),
        .o_sts     (back_sts)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the marker frame receiver: framed byte streams, ticks, replies.
`timescale 1ns / 1ps

module tb
    import amfr_pkg::*;
();

    typedef logic [7:0] t_octets[$];

    typedef enum logic [4:0] {
        SG_IDLE, SG_S, SG_T2, SG_TX, SG_TXE, SG_TXET, SG_TXETX, SG_TXETB,
        SG_O2, SG_OH, SG_OHE, SG_OHET, SG_OHETX, SG_OHETB,
        SG_A, SG_AC, SG_ACK, SG_LRC
    } t_stage;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    ascii_marker_frame_receiver_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  rx_stream[$];
    t_out_item replies_due[$];
    int        queued_items = 0;
    int        errors = 0;

    // Shadow of the receiver state, advanced once per accepted beat.
    t_stage      stage = SG_IDLE;
    logic [7:0]  frame_mem [0:C_BUF_DEPTH-1];
    int          frame_len = 0;
    logic [7:0]  lrc_acc = '0;
    bit          timer_on = 1'b0;
    logic [15:0] timer_left = '0;
    logic [15:0] timeout_cfg = C_TIMEOUT_RESET;
    bit          frame_soh = 1'b0;
    bit          frame_etb = 1'b0;

    function automatic void add_reply(logic [1:0] kind, logic [7:0] data, bit soh, bit etb,
                                      bit last);
        t_out_item r;
        r.reply_kind    = kind;
        r.payload_byte  = data;
        r.start_was_soh = soh;
        r.end_was_etb   = etb;
        r.last          = last;
        replies_due.push_back(r);
    endfunction

    function automatic void compute_replies(t_in_item it);
        logic [7:0] c;
        logic [7:0] prior;
        bit         soh;
        int         len;
        c = it.byte_value;
        if (it.opcode == C_OP_TICK) begin
            if (!timer_on) return;
            if (timer_left <= 16'd1) begin
                timer_on   = 1'b0;
                timer_left = '0;
                stage      = SG_IDLE;
                frame_len  = 0;
                lrc_acc    = '0;
                add_reply(C_KIND_NAK, 8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
                timer_left--;
            end
            return;
        end

        soh = (stage >= SG_O2 && stage <= SG_OHETB);
        case (stage)
            SG_IDLE: begin
                if (c == C_CH_S) stage = SG_S;
                else if (c == C_CH_A) stage = SG_A;
            end
            SG_S: begin
                if (c == C_CH_T) stage = SG_T2;
                else if (c == C_CH_O) stage = SG_O2;
                else if (c == C_CH_S) begin
                    frame_len = 0;
                    lrc_acc   = '0;
                end else stage = SG_IDLE;
            end
            SG_T2, SG_O2: begin
                if ((stage == SG_T2 && c == C_CH_X) || (stage == SG_O2 && c == C_CH_H)) begin
                    stage      = (stage == SG_T2) ? SG_TX : SG_OH;
                    timer_on   = 1'b1;
                    timer_left = timeout_cfg;
                end else if (c == C_CH_S) begin
                    frame_len = 0;
                    lrc_acc   = '0;
                    stage     = SG_S;
                end else stage = SG_IDLE;
            end
            SG_TX, SG_OH: begin
                if (c == C_CH_E) stage = soh ? SG_OHE : SG_TXE;
            end
            SG_TXE, SG_OHE: begin
                if (c == C_CH_T) stage = soh ? SG_OHET : SG_TXET;
                else if (c != C_CH_E) stage = soh ? SG_OH : SG_TX;
            end
            SG_TXET, SG_OHET: begin
                if (c == C_CH_X) stage = soh ? SG_OHETX : SG_TXETX;
                else if (c == C_CH_B) stage = soh ? SG_OHETB : SG_TXETB;
                else if (c == C_CH_E) stage = soh ? SG_OHE : SG_TXE;
                else stage = soh ? SG_OH : SG_TX;
            end
            SG_TXETX, SG_TXETB, SG_OHETX, SG_OHETB: begin
                frame_soh = soh;
                frame_etb = (stage == SG_TXETB || stage == SG_OHETB);
                stage     = SG_LRC;
                timer_on  = 1'b0;
            end
            SG_A: begin
                if (c == C_CH_C) stage = SG_AC;
                else if (c != C_CH_A) stage = SG_IDLE;
            end
            SG_AC: begin
                if (c == C_CH_K) stage = SG_ACK;
                else if (c == C_CH_A) stage = SG_A;
                else stage = SG_IDLE;
            end
            default: stage = SG_IDLE;
        endcase

        if (stage == SG_IDLE || stage == SG_A || stage == SG_AC) begin
            frame_len = 0;
            lrc_acc   = '0;
            return;
        end
        if (stage == SG_ACK) begin
            stage = SG_IDLE;
            return;
        end

        prior = lrc_acc;
        if (frame_len < C_BUF_DEPTH) frame_mem[frame_len] = c;
        lrc_acc ^= c;
        frame_len++;
        // A full store drops the frame silently; the timer is left running.
        if (frame_len >= C_BUF_DEPTH) begin
            stage     = SG_IDLE;
            frame_len = 0;
            lrc_acc   = '0;
            return;
        end
        if (stage != SG_LRC) return;

        len       = frame_len;
        stage     = SG_IDLE;
        frame_len = 0;
        lrc_acc   = '0;
        if (len < C_MIN_FRAME || prior != c ||
            (frame_mem[3] == C_CH_M && frame_mem[4] == C_CH_C && frame_mem[5] == C_CH_T) ||
            (frame_mem[3] == C_CH_X && frame_mem[4] == C_CH_X && frame_mem[5] == C_CH_X)) begin
            add_reply(C_KIND_NAK, 8'h00, 1'b0, 1'b0, 1'b1);
            return;
        end
        add_reply(C_KIND_ACK, 8'h00, 1'b0, 1'b0, len == C_MIN_FRAME);
        for (int i = C_PAY_FIRST; i + 4 < len && i < C_BUF_DEPTH; i++) begin
            add_reply(C_KIND_DATA, frame_mem[i], frame_soh, frame_etb,
                      i + C_PAY_TAIL == len);
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) compute_replies(i_in);
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (rx_stream.size() > 0) begin
                i_in <= rx_stream.pop_front();
                push <= 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 30);
                burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 2) == 0) gap_left = 0;
                    else gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 4);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: checks each popped beat and stalls on a rotating 16-bit mask.
    t_out_item   want;
    logic [15:0] pop_mask = '1;
    logic [3:0]  mask_pos = '0;
    bit          held_off = 1'b0;
    int          hold_left = 0;

    function automatic void check_field(string what, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_val, got_val);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, o_out);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("reply_kind", want.reply_kind, o_out.reply_kind);
                    check_field("payload_byte", want.payload_byte, o_out.payload_byte);
                    check_field("start_was_soh", want.start_was_soh, o_out.start_was_soh);
                    check_field("end_was_etb", want.end_was_etb, o_out.end_was_etb);
                    check_field("last", want.last, o_out.last);
                end
                // One long hold-off while plenty of input is still queued lets the block
                // back up and stall its input.
                if (!held_off && rx_stream.size() > 20) begin
                    hold_left = 400;
                    held_off  = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (mask_pos == 0) pop_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                           : 16'($urandom);
                pop <= pop_mask[mask_pos];
                mask_pos++;
            end
        end
    end

    function automatic void put_byte(logic [7:0] b);
        t_in_item it;
        it.opcode     = C_OP_BYTE;
        it.byte_value = b;
        rx_stream.push_back(it);
        queued_items++;
    endfunction

    function automatic void put_ticks(int n);
        t_in_item it;
        it.opcode = C_OP_TICK;
        for (int i = 0; i < n; i++) begin
            it.byte_value = 8'($urandom);
            rx_stream.push_back(it);
            queued_items++;
        end
    endfunction

    // Start marker, body, end marker and LRC, with optional ticks sprinkled in.
    function automatic void put_frame(bit soh, bit etb, t_octets body, bit bad_lrc,
                                      int tick_odds);
        t_octets    fr;
        logic [7:0] sum;
        fr.push_back(C_CH_S);
        fr.push_back(soh ? C_CH_O : C_CH_T);
        fr.push_back(soh ? C_CH_H : C_CH_X);
        foreach (body[i]) fr.push_back(body[i]);
        fr.push_back(C_CH_E);
        fr.push_back(C_CH_T);
        fr.push_back(etb ? C_CH_B : C_CH_X);
        sum = '0;
        foreach (fr[i]) sum ^= fr[i];
        if (bad_lrc) sum ^= 8'(1 << $urandom_range(0, 7));
        fr.push_back(sum);
        foreach (fr[i]) begin
            put_byte(fr[i]);
            if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1) put_ticks(1);
        end
    endfunction

    function automatic t_octets random_octets(int n);
        t_octets q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic void random_unit(bit ticking);
        int      pick;
        int      n;
        t_octets b;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            case ($urandom_range(0, 9))
                0:       b = '{C_CH_M, C_CH_C, C_CH_T};
                1:       b = '{C_CH_X, C_CH_X, C_CH_X};
                default: b = random_octets(3);
            endcase
            n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 54) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) b.push_back(8'($urandom));
            put_frame($urandom_range(0, 1), $urandom_range(0, 1), b,
                      $urandom_range(0, 9) == 0, ticking ? 6 : 0);
        end else if (pick < 78) begin
            put_byte(C_CH_A);
            if ($urandom_range(0, 2) == 0) put_byte(C_CH_A);
            put_byte(C_CH_C);
            put_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : C_CH_K);
        end else if (pick < 85) begin
            put_frame($urandom_range(0, 1), $urandom_range(0, 1),
                      random_octets($urandom_range(0, 5)), 1'b0, 0);
        end else if (pick < 93) begin
            put_byte(C_CH_S);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 5))
                    0:       put_byte(C_CH_S);
                    1:       put_byte(C_CH_T);
                    2:       put_byte(C_CH_O);
                    3:       put_byte(C_CH_X);
                    4:       put_byte(C_CH_H);
                    default: put_byte(8'($urandom));
                endcase
            end
        end else begin
            // An opened frame that goes quiet; with a short timeout it expires.
            put_byte(C_CH_S);
            if ($urandom_range(0, 1) == 1) begin
                put_byte(C_CH_O);
                put_byte(C_CH_H);
            end else begin
                put_byte(C_CH_T);
                put_byte(C_CH_X);
            end
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) put_byte(8'($urandom));
            put_ticks(ticking ? ((timeout_cfg == 0) ? 1 : int'(timeout_cfg))
                              : $urandom_range(1, 3));
        end
    endfunction

    task automatic write_timeout(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        timeout_cfg = v;
    endtask

    task automatic drain;
        while (rx_stream.size() != 0 || push) @(negedge i_clk);
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_octets b;
        int      mark;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset timeout.
        put_ticks(2);
        put_frame(1'b0, 1'b0, '{C_CH_A, C_CH_B, C_CH_C}, 1'b0, 0);
        put_frame(1'b1, 1'b1, '{C_CH_A, C_CH_C, C_CH_K, 8'h00, 8'hFF}, 1'b0, 0);
        put_frame(1'b0, 1'b1, '{C_CH_M, C_CH_C, C_CH_T, 8'h01}, 1'b0, 0);
        put_frame(1'b1, 1'b0, '{C_CH_X, C_CH_X, C_CH_X}, 1'b0, 0);
        put_frame(1'b0, 1'b0, '{C_CH_B, C_CH_A, C_CH_H, 8'h55}, 1'b1, 0);
        put_frame(1'b0, 1'b0, '{8'h7E, 8'h80}, 1'b0, 0);
        put_byte(C_CH_A);
        put_byte(C_CH_C);
        put_byte(C_CH_K);
        put_byte(C_CH_A);
        put_byte(C_CH_A);
        put_byte(C_CH_C);
        put_byte(C_CH_A);
        put_byte(C_CH_C);
        put_byte(C_CH_K);
        put_byte(C_CH_S);
        put_frame(1'b1, 1'b0, '{C_CH_O, C_CH_K, C_CH_A, 8'h33}, 1'b0, 0);
        put_byte(C_CH_S);
        put_byte(C_CH_T);
        put_frame(1'b0, 1'b1, '{C_CH_S, C_CH_T, C_CH_X, 8'hAA}, 1'b0, 0);
        put_byte(C_CH_S);
        put_byte(C_CH_O);
        put_byte(8'h51);
        put_frame(1'b1, 1'b0, '{C_CH_A, C_CH_B, C_CH_C, C_CH_E, C_CH_E, C_CH_T, C_CH_E,
                                C_CH_T, C_CH_E, 8'h00, C_CH_E, C_CH_T, C_CH_K}, 1'b0, 0);
        b = random_octets(57);
        put_frame(1'b0, 1'b0, b, 1'b0, 0);
        b = random_octets(56);
        put_frame(1'b1, 1'b1, b, 1'b0, 0);
        drain();

        // Shortest timeout, including a timer left running by an overflow.
        write_timeout(16'd1);
        put_byte(C_CH_S);
        put_byte(C_CH_T);
        put_byte(C_CH_X);
        put_ticks(2);
        b = random_octets(60);
        put_frame(1'b0, 1'b1, b, 1'b0, 0);
        put_ticks(1);
        drain();

        // A zero timeout behaves as one tick.
        write_timeout(16'd0);
        put_byte(C_CH_S);
        put_byte(C_CH_O);
        put_byte(C_CH_H);
        put_byte(8'h41);
        put_ticks(1);
        drain();

        write_timeout(16'd2);
        put_byte(C_CH_S);
        put_byte(C_CH_T);
        put_byte(C_CH_X);
        put_ticks(3);
        drain();

        write_timeout(16'hFFFF);
        mark = queued_items;
        while (queued_items - mark < 15) random_unit(1'b0);
        drain();

        write_timeout(16'($urandom_range(5, 40)));
        mark = queued_items;
        while (queued_items - mark < 15) random_unit(1'b1);
        drain();

        if (errors == 0 && replies_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/amfr_pkg.sv
hw/rtl/amfr_jobq.sv
hw/rtl/amfr_front.sv
hw/rtl/amfr_back.sv
hw/rtl/ascii_marker_frame_receiver_core.sv
verif/tb.sv
